[rtl/cbm_pkg.sv]
// shared types and constants for the cartridge bank mapper
package cbm_pkg;

  localparam int unsigned ROM_ADDRESS_BITS = 21;
  localparam int unsigned NumRegions = 8;
  localparam int unsigned RegionW = 3;
  localparam int unsigned BlockW = 8;
  localparam int unsigned OffsetW = 13;
  localparam int unsigned RomAddrW = 21;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [2:0] {
    MapGen8k    = 3'd0,
    MapGen16k   = 3'd1,
    MapScc8k    = 3'd2,
    MapPlain8k  = 3'd3,
    MapAscii8k  = 3'd4,
    MapAscii16k = 3'd5,
    MapDac      = 3'd6,
    MapPlainRom = 3'd7
  } mapper_e;

  localparam logic [CfgIdxW-1:0] CfgMapperType = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlockMask  = 1'b1;

  localparam logic [2:0] ResetMapperType = 3'd7;
  localparam logic [BlockW-1:0] ResetBlockMask = 8'd3;

  localparam logic [5:0] SndKey = 6'h3F;

  typedef struct packed {
    logic [RomAddrW-1:0] rom_address;
    logic                mapped;
    logic                sound_chip_access;
    logic                dac_write;
    logic [7:0]          register_offset;
    logic [7:0]          forwarded_data;
  } result_t;

  typedef struct packed {
    logic [NumRegions-1:0][BlockW-1:0] blocks;
    logic [NumRegions-1:0]             valid;
  } layout_t;

endpackage

[rtl/cartridge_bank_mapper.sv]
// cartridge bank mapper: bus access decode, bank table and result queue
// a request's result enters the queue at the accepting edge and is offered from then on
// throughput: one request per cycle unless stalled; update and translation in the same cycle
// a two-entry result queue takes requests until two results wait unread, then stalls
// reset: plain rom layout with a block mask of three, sound chip disabled, queue empty
// any register write reloads the reset layout for the new setting and disables the sound chip
module cartridge_bank_mapper import cbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [15:0]         address_i,
  input  logic [7:0]          data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RomAddrW-1:0] rom_address_o,
  output logic                mapped_o,
  output logic                sound_chip_access_o,
  output logic                dac_write_o,
  output logic [7:0]          register_offset_o,
  output logic [7:0]          forwarded_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic [RomAddrW-1:0] RomAddrMask =
      RomAddrW'((64'd1 << ROM_ADDRESS_BITS) - 64'd1);

  function automatic layout_t build_layout(mapper_e mt, logic [BlockW-1:0] mask);
    layout_t lay;
    logic [BlockW-1:0] idx;
    for (int i = 0; i < NumRegions; i++) begin
      idx = BlockW'(i);
      lay.blocks[i] = '0;
      lay.valid[i] = 1'b0;
      if (mt != MapPlainRom) begin
        if (i >= 2 && i <= 5) begin
          lay.blocks[i] = (idx - BlockW'(2)) & mask;
          lay.valid[i] = 1'b1;
        end
      end else begin
        lay.valid[i] = 1'b1;
        if (mask == '0) begin
          lay.blocks[i] = '0;
        end else if (mask == BlockW'(1)) begin
          lay.blocks[i] = idx & BlockW'(1) & mask;
        end else if (mask <= BlockW'(3)) begin
          lay.blocks[i] = ((idx & BlockW'(1)) | ((idx >> 1) & BlockW'(2))) & mask;
        end else begin
          lay.blocks[i] = idx & mask;
        end
      end
    end
    return lay;
  endfunction

  mapper_e               type_q;
  logic [BlockW-1:0]     mask_q;
  layout_t               tab_q, tab_d;
  logic                  snd_en_q, snd_en_d;

  logic                  in_fire, out_fire;
  logic                  window;
  logic [RegionW-1:0]    rd_region;
  logic                  wr_a_en, wr_b_en;
  logic [RegionW-1:0]    wr_a_idx;
  logic [BlockW-1:0]     wr_a_blk, wr_b_blk, pair_blk;
  logic                  snd_we, snd_val;
  logic [15:0]           scc_sub;
  result_t               res;

  result_t               queue_q [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            count_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  assign window    = (type_q == MapScc8k) && snd_en_q && (address_i[15:11] == 5'b10011);
  assign rd_region = address_i[15:13];
  assign pair_blk  = {data_i[6:0], 1'b0} & mask_q;
  assign snd_val   = (data_i[5:0] == SndKey);
  assign scc_sub   = address_i - 16'h1000;

  // write decode per scheme
  always_comb begin
    wr_a_en  = 1'b0;
    wr_b_en  = 1'b0;
    wr_a_idx = rd_region;
    wr_a_blk = data_i & mask_q;
    wr_b_blk = (pair_blk + BlockW'(1)) & mask_q;
    snd_we   = 1'b0;
    if (kind_i) begin
      case (type_q)
        MapGen8k: begin
          if (address_i >= 16'h4000 && address_i <= 16'hBFFF) begin
            wr_a_en = 1'b1;
            snd_we  = (address_i[15:13] == 3'b100);
          end
        end
        MapGen16k: begin
          if (address_i >= 16'h4000 && address_i <= 16'hBFFF) begin
            wr_a_en  = 1'b1;
            wr_b_en  = 1'b1;
            wr_a_idx = {address_i[15:14], 1'b0};
            wr_a_blk = pair_blk;
          end
        end
        MapScc8k: begin
          if (!window && address_i >= 16'h5000 && address_i <= 16'hC000) begin
            snd_we   = (address_i[15:11] == 5'b10010);
            wr_a_en  = (address_i[12:11] == 2'b10);
            wr_a_idx = scc_sub[15:13];
          end
        end
        MapPlain8k: begin
          wr_a_en = address_i >= 16'h6000 && address_i <= 16'hA000 &&
                    address_i[12:0] == '0;
        end
        MapAscii8k: begin
          if (address_i >= 16'h6000 && address_i <= 16'h7FFF) begin
            wr_a_en  = 1'b1;
            wr_a_idx = {1'b0, address_i[12:11]} + RegionW'(2);
          end
        end
        MapAscii16k: begin
          if (address_i >= 16'h6000 && address_i <= 16'h77FF && !address_i[11]) begin
            wr_a_en  = 1'b1;
            wr_b_en  = 1'b1;
            wr_a_idx = address_i[12] ? RegionW'(4) : RegionW'(2);
            wr_a_blk = pair_blk;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result of the access against the table before this request
  always_comb begin
    res = '0;
    if (!kind_i) begin
      if (window) begin
        res.sound_chip_access = 1'b1;
        res.register_offset   = address_i[7:0];
      end else if (tab_q.valid[rd_region]) begin
        res.mapped      = 1'b1;
        res.rom_address = {tab_q.blocks[rd_region], address_i[12:0]} & RomAddrMask;
      end
    end else if (window) begin
      res.sound_chip_access = 1'b1;
      res.register_offset   = address_i[7:0];
      res.forwarded_data    = data_i;
    end else if (type_q == MapDac) begin
      res.dac_write      = 1'b1;
      res.forwarded_data = data_i;
    end
  end

  always_comb begin
    tab_d    = tab_q;
    snd_en_d = snd_en_q;
    if (in_fire) begin
      if (wr_a_en) begin
        tab_d.blocks[wr_a_idx] = wr_a_blk;
        tab_d.valid[wr_a_idx]  = 1'b1;
      end
      if (wr_b_en) begin
        tab_d.blocks[wr_a_idx + RegionW'(1)] = wr_b_blk;
        tab_d.valid[wr_a_idx + RegionW'(1)]  = 1'b1;
      end
      if (snd_we) begin
        snd_en_d = snd_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q   <= MapPlainRom;
      mask_q   <= ResetBlockMask;
      tab_q    <= build_layout(mapper_e'(ResetMapperType), ResetBlockMask);
      snd_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      snd_en_q <= 1'b0;
      case (cfg_index_i)
        CfgMapperType: begin
          type_q <= mapper_e'(cfg_data_i[2:0]);
          tab_q  <= build_layout(mapper_e'(cfg_data_i[2:0]), mask_q);
        end
        CfgBlockMask: begin
          mask_q <= cfg_data_i;
          tab_q  <= build_layout(type_q, cfg_data_i);
        end
        default: begin
        end
      endcase
    end else begin
      tab_q    <= tab_d;
      snd_en_q <= snd_en_d;
    end
  end

  // two-entry result queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (out_fire) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, in_fire} - {1'b0, out_fire};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      queue_q[wr_ptr_q] <= res;
    end
  end

  assign in_ready_o          = (count_q != 2'd2);
  assign out_valid_o         = (count_q != 2'd0);
  assign rom_address_o       = queue_q[rd_ptr_q].rom_address;
  assign mapped_o            = queue_q[rd_ptr_q].mapped;
  assign sound_chip_access_o = queue_q[rd_ptr_q].sound_chip_access;
  assign dac_write_o         = queue_q[rd_ptr_q].dac_write;
  assign register_offset_o   = queue_q[rd_ptr_q].register_offset;
  assign forwarded_data_o    = queue_q[rd_ptr_q].forwarded_data;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue count out of range");

  a_fill_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted request left no result");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(mapped_o && (sound_chip_access_o || dac_write_o)))
    else $error("result both mapped and forwarded");

  a_cfg_snd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !snd_en_q)
    else $error("sound chip enable survived register write");

  a_dac_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dac_write_o) |-> (type_q == MapDac))
    else $error("dac write outside dac scheme");

endmodule

[test/cartridge_bank_mapper_tb.sv]
// self-checking testbench for the cartridge bank mapper
module cartridge_bank_mapper_tb import cbm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ParkCycles = 60;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                kind_i;
  logic [15:0]         address_i;
  logic [7:0]          data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [RomAddrW-1:0] rom_address_o;
  logic                mapped_o;
  logic                sound_chip_access_o;
  logic                dac_write_o;
  logic [7:0]          register_offset_o;
  logic [7:0]          forwarded_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  cartridge_bank_mapper i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .address_i,
    .data_i,
    .out_valid_o,
    .out_ready_i,
    .rom_address_o,
    .mapped_o,
    .sound_chip_access_o,
    .dac_write_o,
    .register_offset_o,
    .forwarded_data_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  // predicted mapper state
  mapper_e           cur_type;
  logic [BlockW-1:0] cur_mask;
  logic [BlockW-1:0] bank_blk [NumRegions];
  logic              bank_ok  [NumRegions];
  logic              snd_on;

  result_t     expected_translations [$];
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned sent = 0;
  int unsigned modes = 0;
  int unsigned cycle_count = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  bit          park_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void bank_put(input logic [RegionW-1:0] r, input logic [BlockW-1:0] b);
    bank_blk[r] = b & cur_mask;
    bank_ok[r]  = 1'b1;
  endfunction

  function automatic void bank_put_pair(input logic [RegionW-1:0] r, input logic [7:0] d);
    logic [BlockW-1:0] b;
    b = {d[6:0], 1'b0} & cur_mask;
    bank_put(r, b);
    bank_put(r + 3'd1, b + 8'd1);
  endfunction

  function automatic void bank_reload();
    for (int i = 0; i < NumRegions; i++) begin
      bank_blk[i] = '0;
      bank_ok[i]  = 1'b0;
    end
    for (int i = 0; i < NumRegions; i++) begin
      if (cur_type != MapPlainRom) begin
        if (i < 4) bank_put(3'(i + 2), 8'(i));
      end else if (cur_mask == 8'd0) begin
        bank_put(3'(i), 8'd0);
      end else if (cur_mask == 8'd1) begin
        bank_put(3'(i), 8'(i & 1));
      end else if (cur_mask <= 8'd3) begin
        bank_put(3'(i), 8'((i & 1) | ((i >> 1) & 2)));
      end else begin
        bank_put(3'(i), 8'(i));
      end
    end
    snd_on = 1'b0;
  endfunction

  // translate one bus access and apply its bank or enable update
  function automatic result_t translate_access(input logic wr, input logic [15:0] a,
                                               input logic [7:0] d);
    result_t          res;
    logic             win;
    logic [RegionW-1:0] r;
    res = '0;
    win = (cur_type == MapScc8k) && snd_on && ((a & 16'hF800) == 16'h9800);
    if (!wr) begin
      if (win) begin
        res.sound_chip_access = 1'b1;
        res.register_offset   = a[7:0];
      end else begin
        r = a[15:13];
        if (bank_ok[r]) begin
          res.mapped      = 1'b1;
          res.rom_address = {bank_blk[r], a[12:0]};
        end
      end
    end else begin
      case (cur_type)
        MapGen8k: begin
          if (a >= 16'h4000 && a <= 16'hBFFF) begin
            if ((a & 16'hE000) == 16'h8000) snd_on = (d[5:0] == SndKey);
            bank_put(a[15:13], d);
          end
        end
        MapGen16k: begin
          if (a >= 16'h4000 && a <= 16'hBFFF) bank_put_pair({a[15:14], 1'b0}, d);
        end
        MapScc8k: begin
          if (win) begin
            res.sound_chip_access = 1'b1;
            res.register_offset   = a[7:0];
            res.forwarded_data    = d;
          end else if (a >= 16'h5000 && a <= 16'hC000) begin
            if ((a & 16'hF800) == 16'h9000) snd_on = (d[5:0] == SndKey);
            if ((a & 16'h1800) == 16'h1000) bank_put(3'((a - 16'h1000) >> 13), d);
          end
        end
        MapPlain8k: begin
          if (a >= 16'h6000 && a <= 16'hA000 && a[12:0] == 13'd0) bank_put(a[15:13], d);
        end
        MapAscii8k: begin
          if (a >= 16'h6000 && a <= 16'h7FFF) bank_put(3'(a[12:11]) + 3'd2, d);
        end
        MapAscii16k: begin
          if (a >= 16'h6000 && a <= 16'h77FF && !a[11]) bank_put_pair({1'b0, a[12], 1'b0} + 3'd2, d);
        end
        MapDac: begin
          res.dac_write      = 1'b1;
          res.forwarded_data = d;
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // random access; writes are mostly aimed at the bank registers of the current scheme
  function automatic void pick_access(output logic wr, output logic [15:0] a,
                                      output logic [7:0] d);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    a   = 16'($urandom_range(0, 65535));
    d   = 8'($urandom_range(0, 255));
    wr  = 1'b1;
    if (sel < 40) begin
      wr = 1'b0;
      if (cur_type == MapScc8k && $urandom_range(0, 2) == 0) a = 16'h9800 | {5'd0, a[10:0]};
    end else if (sel < 88) begin
      if ($urandom_range(0, 3) == 0) d[5:0] = SndKey;
      case (cur_type)
        MapGen8k, MapGen16k: a = 16'h4000 + 16'($urandom_range(0, 16'h7FFF));
        MapScc8k: begin
          if ($urandom_range(0, 4) == 0) a = 16'h9800 | {5'd0, a[10:0]};
          else a = 16'h5000 + 16'($urandom_range(0, 3)) * 16'h2000 + {5'd0, a[10:0]};
        end
        MapPlain8k: a = 16'h6000 + 16'($urandom_range(0, 2)) * 16'h2000 + 16'($urandom_range(0, 1));
        MapAscii8k, MapAscii16k: a = 16'h6000 | {3'd0, a[12:0]};
        default: ;
      endcase
    end
  endfunction

  task automatic send_access(input logic wr, input logic [15:0] a, input logic [7:0] d);
    in_valid_i <= 1'b1;
    kind_i     <= wr;
    address_i  <= a;
    data_i     <= d;
    do @(posedge clk_i); while (!in_ready_o);
    expected_translations.push_back(translate_access(wr, a, d));
    sent++;
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input int unsigned n);
    logic        wr;
    logic [15:0] a;
    logic [7:0]  d;
    repeat (n) begin
      pick_access(wr, a, d);
      send_access(wr, a, d);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_translations.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMapperType) cur_type = mapper_e'(val[2:0]);
    else cur_mask = val;
    bank_reload();
    @(posedge clk_i);
  endtask

  task automatic set_mode(input mapper_e t, input logic [BlockW-1:0] m);
    drain_results();
    write_reg(CfgMapperType, {5'd0, t});
    write_reg(CfgBlockMask, m);
    modes++;
  endtask

  task automatic test_reset_layout();
    send_access(1'b0, 16'h0000, 8'h00);
    send_access(1'b0, 16'h7FFF, 8'hFF);
    send_access(1'b0, 16'hFFFF, 8'h00);
    send_access(1'b1, 16'h6000, 8'hFF);
    send_access(1'b0, 16'h6000, 8'h00);
  endtask

  task automatic test_bank_schemes();
    set_mode(MapGen8k, 8'hFF);
    send_access(1'b0, 16'h0000, 8'h00);
    send_access(1'b1, 16'h8000, 8'hFF);
    send_access(1'b0, 16'h9FFF, 8'h00);
    set_mode(MapGen16k, 8'h0F);
    send_access(1'b1, 16'hA000, 8'hFF);
    send_access(1'b0, 16'hBFFF, 8'h00);
    set_mode(MapPlain8k, 8'h07);
    send_access(1'b1, 16'hA001, 8'h05);
    send_access(1'b1, 16'hA000, 8'h0D);
    send_access(1'b0, 16'hA000, 8'h00);
    set_mode(MapAscii8k, 8'h3F);
    send_access(1'b1, 16'h7800, 8'h2A);
    send_access(1'b0, 16'hB000, 8'h00);
    set_mode(MapAscii16k, 8'hFF);
    send_access(1'b1, 16'h7000, 8'h80);
    send_access(1'b1, 16'h6800, 8'h11);
    send_access(1'b0, 16'h9000, 8'h00);
    send_access(1'b0, 16'hA000, 8'h00);
  endtask

  task automatic test_sound_window();
    set_mode(MapScc8k, 8'hFF);
    send_access(1'b1, 16'h9000, 8'h3F);
    send_access(1'b0, 16'h9800, 8'h00);
    send_access(1'b1, 16'h9FFF, 8'hA5);
    send_access(1'b1, 16'h9000, 8'h00);
    send_access(1'b0, 16'h9800, 8'h00);
  endtask

  task automatic test_dac_and_rom_layouts();
    set_mode(MapDac, 8'hFF);
    send_access(1'b1, 16'h0000, 8'h5A);
    set_mode(MapPlainRom, 8'h00);
    send_access(1'b0, 16'hE000, 8'h00);
    set_mode(MapPlainRom, 8'h01);
    send_access(1'b0, 16'h2000, 8'h00);
    set_mode(MapPlainRom, 8'h80);
    send_access(1'b0, 16'hE000, 8'h00);
  endtask

  // output side parks while requests keep coming, so the input must stall
  task automatic test_result_backlog();
    set_mode(MapGen8k, 8'h1F);
    tx_gaps  = 1'b0;
    park_req = 1'b1;
    send_random(40);
    tx_gaps = 1'b1;
  endtask

  task automatic test_sender_pause();
    set_mode(MapScc8k, 8'h3F);
    send_random(12);
    drain_results();
    send_random(12);
  endtask

  task automatic test_random_traffic();
    logic [BlockW-1:0] masks [11];
    logic [BlockW-1:0] m;
    masks = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F, 8'hFF, 8'h00};
    for (int p = 0; p < 24; p++) begin
      m = ((p * 5) % 11 == 10) ? 8'($urandom_range(0, 255)) : masks[(p * 5) % 11];
      set_mode(mapper_e'(p % 8), m);
      tx_gaps = (p < 21) && (p % 5 != 2);
      rx_gaps = tx_gaps;
      send_random(72);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_translations.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        exp_r = expected_translations.pop_front();
        checked++;
        check_field("rom_address", 32'(exp_r.rom_address), 32'(rom_address_o));
        check_field("mapped", 32'(exp_r.mapped), 32'(mapped_o));
        check_field("sound_chip_access", 32'(exp_r.sound_chip_access),
                    32'(sound_chip_access_o));
        check_field("dac_write", 32'(exp_r.dac_write), 32'(dac_write_o));
        check_field("register_offset", 32'(exp_r.register_offset), 32'(register_offset_o));
        check_field("forwarded_data", 32'(exp_r.forwarded_data), 32'(forwarded_data_o));
      end
    end
  end

  // result side: random stalls plus one long park on request
  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (park_req) begin
        park_req    = 1'b0;
        stall_left  = ParkCycles - 1;
        out_ready_i <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        stall_left  = $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = 1'b0;
    address_i   = '0;
    data_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CfgMapperType;
    cfg_data_i  = '0;
    cur_type    = mapper_e'(ResetMapperType);
    cur_mask    = ResetBlockMask;
    bank_reload();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_layout();
    test_bank_schemes();
    test_sound_window();
    test_dac_and_rom_layouts();
    test_result_backlog();
    test_sender_pause();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (expected_translations.size() != 0) begin
      $error("%0d results never arrived", expected_translations.size());
      mismatches++;
    end
    $display("%0d bus requests over %0d mapper settings, %0d results compared",
             sent, modes, checked);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
rtl/cbm_pkg.sv
rtl/cartridge_bank_mapper.sv
test/cartridge_bank_mapper_tb.sv
